>>> rtl/tdl_pkg.sv
`timescale 1ns / 1ps

package tdl_pkg;

    localparam int NUM_STATES_DEF  = 64;
    localparam int NUM_CLASSES_DEF = 32;
    localparam int LINE_LENGTH_DEF = 256;

    localparam int CMDQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 4;

    localparam logic [7:0] SPACE_CODE = 8'd32;

    // Function codes of an input word.
    localparam logic [2:0] FN_LOAD_CLASS = 3'd0;
    localparam logic [2:0] FN_LOAD_TRANS = 3'd1;
    localparam logic [2:0] FN_LOAD_KIND  = 3'd2;
    localparam logic [2:0] FN_SCAN       = 3'd3;
    localparam logic [2:0] FN_EOL        = 3'd4;

    // State kinds.
    localparam logic [1:0] KIND_PLAIN   = 2'd0;
    localparam logic [1:0] KIND_RETRACT = 2'd1;
    localparam logic [1:0] KIND_ACCEPT  = 2'd2;

    // Token kinds.
    localparam logic [1:0] TOK_ACCEPT  = 2'd0;
    localparam logic [1:0] TOK_RETRACT = 2'd1;
    localparam logic [1:0] TOK_ERROR   = 2'd2;
    localparam logic [1:0] TOK_SPACE   = 2'd3;

    typedef enum logic [2:0] {
        OP_LOAD_TRANS,
        OP_LOAD_KIND,
        OP_SCAN,
        OP_SPACE,
        OP_EOL
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              cls_ok;
        logic [4:0]        cls;
        logic [5:0]        row;
        logic [4:0]        ld_col;
        logic signed [6:0] tgt;
        logic [1:0]        kind;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] first;
        logic [7:0] tok_end;
        logic       last;
    } t_res;

endpackage

>>> rtl/tdl_front.sv
`timescale 1ns / 1ps

module tdl_front import tdl_pkg::*; #(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [2:0]        i_func,
    input  logic [7:0]        i_char_code,
    input  logic signed [5:0] i_char_class,
    input  logic [5:0]        i_from_state,
    input  logic [4:0]        i_on_class,
    input  logic signed [6:0] i_next_state,
    input  logic [1:0]        i_kind_value,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_ready
);

    logic [5:0]   r_map [256];
    logic [255:0] r_map_vld;
    logic [5:0]   r_map_q;
    logic         r_map_vq;

    logic              r_v;
    t_op               r_op;
    logic [5:0]        r_row;
    logic [4:0]        r_ld_col;
    logic signed [6:0] r_tgt;
    logic [1:0]        r_kind;

    logic accept;
    logic fwd;
    t_op  op;
    logic [5:0] cls_s;

    assign o_full      = r_v && !i_cmd_ready;
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = r_v;

    always_comb begin
        fwd = 1'b1;
        op  = OP_SCAN;
        unique case (i_func)
            FN_LOAD_TRANS: op = OP_LOAD_TRANS;
            FN_LOAD_KIND:  op = OP_LOAD_KIND;
            FN_SCAN:       op = (i_char_code == SPACE_CODE) ? OP_SPACE : OP_SCAN;
            FN_EOL:        op = OP_EOL;
            default:       fwd = 1'b0;
        endcase
    end

    // Class map: written and read when a word is taken in.
    always_ff @(posedge i_clk) begin
        if (accept && i_func == FN_LOAD_CLASS) begin
            r_map[i_char_code] <= i_char_class;
        end
        if (accept) begin
            r_map_q  <= r_map[i_char_code];
            r_map_vq <= r_map_vld[i_char_code];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
            r_v       <= 1'b0;
        end else begin
            if (accept && i_func == FN_LOAD_CLASS) begin
                r_map_vld[i_char_code] <= 1'b1;
            end
            if (accept) begin
                r_v <= fwd;
            end else if (i_cmd_ready) begin
                r_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= op;
            r_row    <= i_from_state;
            r_ld_col <= i_on_class;
            r_tgt    <= i_next_state;
            r_kind   <= i_kind_value;
        end
    end

    // An unmapped character reads as class -1.
    assign cls_s = r_map_vq ? r_map_q : 6'h3F;

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = r_op;
        o_cmd.cls_ok = !cls_s[5] && (32'(cls_s[4:0]) < NUM_CLASSES);
        o_cmd.cls    = cls_s[4:0];
        o_cmd.row    = r_row;
        o_cmd.ld_col = r_ld_col;
        o_cmd.tgt    = r_tgt;
        o_cmd.kind   = r_kind;
    end

    a_class_load_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_func == FN_LOAD_CLASS |=> !o_cmd_valid)
        else $error("class load produced an engine command");

    a_scan_forwarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_func == FN_SCAN |=> o_cmd_valid && (o_cmd.op == OP_SCAN || o_cmd.op == OP_SPACE))
        else $error("scanned character not forwarded");

endmodule

>>> rtl/tdl_cmd_fifo.sv
`timescale 1ns / 1ps

module tdl_cmd_fifo import tdl_pkg::*; #(
    parameter int DEPTH = CMDQ_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_cmd i_wr_data,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_cmd o_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CNTW-1:0] r_cnt;

    logic wr;
    logic rd;

    assign o_wr_ready = r_cnt != CNTW'(DEPTH);
    assign o_rd_valid = r_cnt != '0;
    assign wr         = i_wr_valid && o_wr_ready;
    assign rd         = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNTW'(wr) - CNTW'(rd);
        end
    end

endmodule

>>> rtl/tdl_res_fifo.sv
`timescale 1ns / 1ps

module tdl_res_fifo import tdl_pkg::*; #(
    parameter int DEPTH = RESQ_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_wr_cnt,
    input  t_res       i_wr0,
    input  t_res       i_wr1,
    output logic       o_room2,
    output logic       o_empty,
    input  logic       i_pop,
    output t_res       o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    t_res            r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CNTW-1:0] r_cnt;

    logic rd;

    // The engine writes only when two entries are free, so no write is refused.
    assign o_room2 = r_cnt <= CNTW'(DEPTH - 2);
    assign o_empty = r_cnt == '0;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_mem[r_wp] <= i_wr0;
        end
        if (i_wr_cnt == 2'd2) begin
            r_mem[r_wp + 1'b1] <= i_wr1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= r_wp + AW'(i_wr_cnt);
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNTW'(i_wr_cnt) - CNTW'(rd);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_cnt != 2'd0 |-> r_cnt + CNTW'(i_wr_cnt) <= CNTW'(DEPTH))
        else $error("result queue overflow");

endmodule

>>> rtl/tdl_back.sv
`timescale 1ns / 1ps

module tdl_back import tdl_pkg::*; #(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_ready,
    output logic [1:0] o_res_cnt,
    output t_res       o_res0,
    output t_res       o_res1,
    input  logic       i_res_room
);

    localparam int SW = $clog2(NUM_STATES);
    localparam int AW = $clog2(NUM_STATES * NUM_CLASSES);
    localparam int PW = $clog2(LINE_LENGTH);
    localparam logic [SW-1:0] START = SW'(1);
    localparam logic [PW-1:0] POS_MAX = PW'(LINE_LENGTH - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRANS,
        PH_KIND,
        PH_SPACE
    } t_phase;

    logic [6:0]            r_trans [NUM_STATES * NUM_CLASSES];
    logic [1:0]            r_kinds [NUM_STATES];
    logic [NUM_STATES-1:0] r_kind_vld;
    logic [6:0]            r_trans_q;
    logic [1:0]            r_kind_q;
    logic                  r_kind_vq;

    t_phase        r_phase, n_phase;
    logic [SW-1:0] r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_begin, n_begin;
    logic          r_pass, n_pass;
    logic [4:0]    r_col, n_col;
    logic          r_col_ok, n_col_ok;
    logic [SW-1:0] r_ns;
    logic          r_ns_ok;
    logic          r_pend_v, n_pend_v;
    t_res          r_pend, n_pend;

    logic          fin;
    logic          pop;
    logic          empty;
    logic [PW-1:0] pos_nx;
    logic [PW-1:0] pos_pv;
    logic [1:0]    kind_eff;
    logic          brk;
    logic          emit;
    t_res          new_res;
    logic          ns_ok;
    logic [SW-1:0] ka;
    logic [4:0]    rd_col;
    logic          rd_ok;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign empty  = r_begin == r_pos;
    assign pos_nx = (r_pos == POS_MAX) ? '0 : r_pos + 1'b1;
    assign pos_pv = (r_pos == '0) ? POS_MAX : r_pos - 1'b1;

    // Target of the transition just read; out of range means an error move.
    assign ns_ok = r_col_ok && !r_trans_q[6] && (32'(r_trans_q[5:0]) < NUM_STATES);
    assign ka    = SW'(r_trans_q[5:0]);

    // Only retract and accept states act on their kind; every other kind is plain.
    assign kind_eff = (r_kind_vq && (r_kind_q == KIND_RETRACT || r_kind_q == KIND_ACCEPT))
                      ? r_kind_q : KIND_PLAIN;
    assign brk      = !r_ns_ok || kind_eff == KIND_RETRACT;

    always_comb begin
        n_phase   = r_phase;
        n_state   = r_state;
        n_pos     = r_pos;
        n_begin   = r_begin;
        n_pass    = r_pass;
        n_col     = r_col;
        n_col_ok  = r_col_ok;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        fin       = 1'b0;
        emit      = 1'b0;
        new_res   = '0;
        o_res_cnt = 2'd0;
        o_res0    = '0;
        o_res1    = '0;

        unique case (r_phase)
            PH_IDLE: begin
                fin = 1'b1;
            end
            PH_TRANS: begin
                n_phase = PH_KIND;
            end
            PH_KIND: begin
                if (i_res_room) begin
                    if (brk && !empty) begin
                        // Token ends before this character; feed it again from the start.
                        n_pend_v        = 1'b1;
                        n_pend.kind     = r_ns_ok ? TOK_RETRACT : TOK_ERROR;
                        n_pend.first    = 8'(r_begin);
                        n_pend.tok_end  = 8'(pos_pv);
                        n_pend.last     = 1'b0;
                        n_state         = START;
                        n_begin         = r_pos;
                        n_pass          = 1'b1;
                        n_phase         = PH_TRANS;
                    end else begin
                        fin = 1'b1;
                        if (brk) begin
                            emit            = 1'b1;
                            new_res.kind    = TOK_ERROR;
                            new_res.first   = 8'(r_pos);
                            new_res.tok_end = 8'(r_pos);
                            n_state         = START;
                            n_pos           = pos_nx;
                            n_begin         = pos_nx;
                        end else if (kind_eff == KIND_ACCEPT) begin
                            emit            = 1'b1;
                            new_res.kind    = TOK_ACCEPT;
                            new_res.first   = 8'(r_begin);
                            new_res.tok_end = 8'(r_pos);
                            n_state         = START;
                            n_pos           = pos_nx;
                            n_begin         = pos_nx;
                        end else begin
                            n_state = r_ns;
                            n_pos   = pos_nx;
                        end
                    end
                end
            end
            PH_SPACE: begin
                if (i_res_room) begin
                    fin             = 1'b1;
                    emit            = !empty;
                    new_res.kind    = TOK_SPACE;
                    new_res.first   = 8'(r_begin);
                    new_res.tok_end = 8'(pos_pv);
                    n_state         = START;
                    n_pos           = pos_nx;
                    n_begin         = pos_nx;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // A held result goes out ahead of the one found in the second pass.
        if (fin) begin
            new_res.last = 1'b1;
            if (r_pend_v && emit) begin
                o_res_cnt = 2'd2;
                o_res0    = r_pend;
                o_res1    = new_res;
            end else if (r_pend_v) begin
                o_res_cnt   = 2'd1;
                o_res0      = r_pend;
                o_res0.last = 1'b1;
            end else if (emit) begin
                o_res_cnt = 2'd1;
                o_res0    = new_res;
            end
            n_pend_v = 1'b0;
            n_phase  = PH_IDLE;
        end

        pop = fin && i_cmd_valid;
        if (pop) begin
            unique case (i_cmd.op)
                OP_SCAN: begin
                    n_phase  = PH_TRANS;
                    n_col    = i_cmd.cls;
                    n_col_ok = i_cmd.cls_ok;
                    n_pass   = 1'b0;
                end
                OP_SPACE: begin
                    n_phase = PH_SPACE;
                end
                OP_EOL: begin
                    n_state = START;
                    n_pos   = '0;
                    n_begin = '0;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign o_cmd_ready = fin;

    // Transition read for the character that starts its lookup at this edge.
    assign rd_col  = pop ? i_cmd.cls : r_col;
    assign rd_ok   = pop ? i_cmd.cls_ok : r_col_ok;
    assign rd_addr = rd_ok ? AW'(n_state) * AW'(NUM_CLASSES) + AW'(rd_col) : '0;
    assign wr_addr = AW'(i_cmd.row) * AW'(NUM_CLASSES) + AW'(i_cmd.ld_col);

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.op == OP_LOAD_TRANS && 32'(i_cmd.row) < NUM_STATES
                && 32'(i_cmd.ld_col) < NUM_CLASSES) begin
            r_trans[wr_addr] <= i_cmd.tgt;
        end
        if (pop && i_cmd.op == OP_LOAD_KIND && 32'(i_cmd.row) < NUM_STATES) begin
            r_kinds[SW'(i_cmd.row)] <= i_cmd.kind;
        end
        r_trans_q <= r_trans[rd_addr];
        r_kind_q  <= r_kinds[ka];
        r_kind_vq <= r_kind_vld[ka];
        r_ns      <= ka;
        r_ns_ok   <= ns_ok;
        r_col     <= n_col;
        r_col_ok  <= n_col_ok;
        r_pend    <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_state    <= START;
            r_pos      <= '0;
            r_begin    <= '0;
            r_pass     <= 1'b0;
            r_pend_v   <= 1'b0;
            r_kind_vld <= '0;
        end else begin
            r_phase  <= n_phase;
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_begin  <= n_begin;
            r_pass   <= n_pass;
            r_pend_v <= n_pend_v;
            if (pop && i_cmd.op == OP_LOAD_KIND && 32'(i_cmd.row) < NUM_STATES) begin
                r_kind_vld[SW'(i_cmd.row)] <= 1'b1;
            end
        end
    end

    a_pend_in_second_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> r_pass)
        else $error("held result outside a second pass");

    a_pair_last_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_cnt == 2'd2 |-> (o_res1.last && !o_res0.last))
        else $error("wrong last flags on a result pair");

    a_decide_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_KIND && !i_res_room |=> r_phase == PH_KIND && $stable(r_state))
        else $error("engine advanced without result room");

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_state) < NUM_STATES)
        else $error("scan state out of range");

endmodule

>>> rtl/table_driven_lexer_dfa_core.sv
`timescale 1ns / 1ps

// Chan  Handshake  Fields
// in    push/full  func, char_code, char_class, from_state, on_class, next_state, kind_value
// out   empty/pop  token_kind, token_first, token_end, last
//
// The front takes one word per cycle while its four-entry command queue has room.
// The engine takes a load or end-of-line word as it pops it; a space word passes a space
// phase, a scanned character a transition table read, then a state kind read, and a
// retracted character both reads again. Reset is synchronous and clears the class map
// and state kind valid bits; the transition table holds nothing defined until loaded.
// A character finishes only when the result queue has two free entries.

module table_driven_lexer_dfa_core import tdl_pkg::*; #(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [2:0]        i_func,
    input  logic [7:0]        i_char_code,
    input  logic signed [5:0] i_char_class,
    input  logic [5:0]        i_from_state,
    input  logic [4:0]        i_on_class,
    input  logic signed [6:0] i_next_state,
    input  logic [1:0]        i_kind_value,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        o_token_kind,
    output logic [7:0]        o_token_first,
    output logic [7:0]        o_token_end,
    output logic              o_last
);

    logic       f_valid;
    t_cmd       f_cmd;
    logic       f_ready;
    logic       q_valid;
    t_cmd       q_cmd;
    logic       q_ready;
    logic [1:0] res_cnt;
    t_res       res0;
    t_res       res1;
    logic       res_room;
    t_res       res_head;

    tdl_front #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_char_class (i_char_class),
        .i_from_state (i_from_state),
        .i_on_class   (i_on_class),
        .i_next_state (i_next_state),
        .i_kind_value (i_kind_value),
        .o_cmd_valid  (f_valid),
        .o_cmd        (f_cmd),
        .i_cmd_ready  (f_ready)
    );

    tdl_cmd_fifo #(
        .DEPTH(CMDQ_DEPTH)
    ) u_cmd_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_data  (f_cmd),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_cmd)
    );

    tdl_back #(
        .NUM_STATES  (NUM_STATES),
        .NUM_CLASSES (NUM_CLASSES),
        .LINE_LENGTH (LINE_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .o_res_cnt   (res_cnt),
        .o_res0      (res0),
        .o_res1      (res1),
        .i_res_room  (res_room)
    );

    tdl_res_fifo #(
        .DEPTH(RESQ_DEPTH)
    ) u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_cnt (res_cnt),
        .i_wr0    (res0),
        .i_wr1    (res1),
        .o_room2  (res_room),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_data   (res_head)
    );

    assign o_token_kind  = res_head.kind;
    assign o_token_first = res_head.first;
    assign o_token_end   = res_head.tok_end;
    assign o_last        = res_head.last;

endmodule
